// ===== hw/rtl/running_median_two_heaps_core_assert.svh =====
// Assertion macros used by the running median core.
`ifndef RUNNING_MEDIAN_TWO_HEAPS_CORE_ASSERT_SVH
`define RUNNING_MEDIAN_TWO_HEAPS_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, masked during reset.
`define RMH_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("running median assertion failed");

// Next-cycle implication, sampled on clk, masked during reset.
`define RMH_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("running median assertion failed");

`endif

// ===== hw/rtl/rmh_pkg.sv =====
// Package: shared types and default constants of the running median block.
package rmh_pkg;

    localparam int CAPACITY_DEF     = 1024;
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int HELD_WIDTH       = 11;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP_RD,
        ST_UP_CMP,
        ST_DN_L,
        ST_DN_R,
        ST_DN_C,
        ST_FIN
    } state_t;

    typedef enum logic {
        HEAP_UPPER,
        HEAP_LOWER
    } heap_t;

endpackage

// ===== hw/rtl/running_median_two_heaps_core.sv =====
// Top level: running median of a sample stream using a min-heap and a max-heap.
//
// Input channel: in_valid / in_stall carry sample (signed) and restart.
// Output channel: out_valid / out_stall carry median_doubled (twice the median,
// signed), samples_held and dropped. One result word per input word.
// A word moves when valid is high and stall is low at a rising clock edge.
// A dropped word goes from ST_IDLE straight to ST_FIN. A stored word runs a
// heap sift-up (ST_UP_RD and ST_UP_CMP per level, ST_UP_RD alone at the root)
// and, when the heaps must rebalance, first a sift-down (ST_DN_L, ST_DN_R and
// ST_DN_C per level) of the heap that takes the sample, whose old top then
// moves to the other heap. Each heap memory has a single read port. After the
// heap steps, ST_FIN loads the result into the output register.
// Items are handled one at a time; in_stall is high while an item is in work.
// A finished result sits in the output register; the next item is taken
// while it waits, and the block holds in its final step if the receiver
// still stalls when the following result is ready.
// Reset clears both heap counts and the output valid; heap memories are not
// cleared. restart empties both heaps before its sample is taken.
module running_median_two_heaps_core #(
    parameter int CAPACITY     = rmh_pkg::CAPACITY_DEF,
    parameter int SAMPLE_WIDTH = rmh_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]     sample,
    input  logic                               restart,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [SAMPLE_WIDTH:0]       median_doubled,
    output logic [rmh_pkg::HELD_WIDTH-1:0]     samples_held,
    output logic                               dropped
);

    import rmh_pkg::*;

    localparam int SW    = SAMPLE_WIDTH;
    localparam int DEPTH = (CAPACITY + 1) / 2;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int IW    = CW + 1;
    localparam int TW    = (CW + 1 > HELD_WIDTH) ? CW + 1 : HELD_WIDTH;

    function automatic logic ranks(input heap_t h, input logic signed [SW-1:0] a,
                                   input logic signed [SW-1:0] b);
        ranks = (h == HEAP_LOWER) ? (a > b) : (a < b);
    endfunction

    state_t                state_reg, state_next;
    heap_t                 sel_reg, sel_next;
    logic signed [SW-1:0]  val_reg, val_next;
    logic [AW-1:0]         idx_reg, idx_next;
    logic [CW-1:0]         n_reg, n_next;
    logic signed [SW-1:0]  best_val_reg, best_val_next;
    logic [AW-1:0]         best_idx_reg, best_idx_next;
    logic                  found_reg, found_next;
    logic                  has_r_reg, has_r_next;
    logic signed [SW-1:0]  moved_reg, moved_next;
    logic [CW-1:0]         uc_reg, uc_next;
    logic [CW-1:0]         lc_reg, lc_next;
    logic signed [SW-1:0]  utop_reg, ltop_reg;
    logic                  drop_reg, drop_next;
    logic                  out_valid_reg, out_valid_next;
    logic signed [SW:0]    med_reg, med_next;
    logic [HELD_WIDTH-1:0] held_reg, held_next;
    logic                  odrop_reg;

    logic                  wen, wen_up, wen_lo;
    logic [AW-1:0]         waddr, raddr;
    logic signed [SW-1:0]  wdata;
    logic [SW-1:0]         rdata_up, rdata_lo;
    logic signed [SW-1:0]  rdata;

    logic [CW-1:0]         eff_uc, eff_lc;
    logic [TW-1:0]         eff_total, total;
    logic [IW-1:0]         child_l, child_r, parent;
    heap_t                 other;
    logic [CW-1:0]         other_cnt;

    assign wen_up = wen && (sel_reg == HEAP_UPPER);
    assign wen_lo = wen && (sel_reg == HEAP_LOWER);
    assign rdata  = (sel_reg == HEAP_LOWER) ? $signed(rdata_lo) : $signed(rdata_up);

    rmh_ram #(.WIDTH(SW), .DEPTH(DEPTH), .AW(AW)) u_upper (
        .clk   (clk),
        .we    (wen_up),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_up)
    );

    rmh_ram #(.WIDTH(SW), .DEPTH(DEPTH), .AW(AW)) u_lower (
        .clk   (clk),
        .we    (wen_lo),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_lo)
    );

    assign eff_uc    = restart ? '0 : uc_reg;
    assign eff_lc    = restart ? '0 : lc_reg;
    assign eff_total = TW'(eff_uc) + TW'(eff_lc);
    assign total     = TW'(uc_reg) + TW'(lc_reg);
    assign child_l   = {idx_reg, 1'b1} + IW'(0);
    assign child_r   = child_l + IW'(1);
    assign parent    = (IW'(idx_reg) - IW'(1)) >> 1;
    assign other     = (sel_reg == HEAP_UPPER) ? HEAP_LOWER : HEAP_UPPER;
    assign other_cnt = (sel_reg == HEAP_UPPER) ? lc_reg : uc_reg;

    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        val_next       = val_reg;
        idx_next       = idx_reg;
        n_next         = n_reg;
        best_val_next  = best_val_reg;
        best_idx_next  = best_idx_reg;
        found_next     = found_reg;
        has_r_next     = has_r_reg;
        moved_next     = moved_reg;
        uc_next        = uc_reg;
        lc_next        = lc_reg;
        drop_next      = drop_reg;
        out_valid_next = out_valid_reg && out_stall;
        med_next       = med_reg;
        held_next      = held_reg;
        wen            = 1'b0;
        waddr          = idx_reg;
        wdata          = val_reg;
        raddr          = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    uc_next   = eff_uc;
                    lc_next   = eff_lc;
                    drop_next = 1'b0;
                    if (eff_total >= TW'(CAPACITY))
                    begin
                        drop_next  = 1'b1;
                        state_next = ST_FIN;
                    end
                    else if (eff_uc == '0 || utop_reg < sample)
                    begin
                        if (eff_uc == eff_lc)
                        begin
                            sel_next   = HEAP_UPPER;
                            val_next   = sample;
                            idx_next   = AW'(eff_uc);
                            uc_next    = eff_uc + CW'(1);
                            state_next = ST_UP_RD;
                        end
                        else
                        begin
                            sel_next   = HEAP_UPPER;
                            val_next   = sample;
                            idx_next   = '0;
                            n_next     = eff_uc;
                            moved_next = utop_reg;
                            state_next = ST_DN_L;
                        end
                    end
                    else if (eff_uc > eff_lc)
                    begin
                        sel_next   = HEAP_LOWER;
                        val_next   = sample;
                        idx_next   = AW'(eff_lc);
                        lc_next    = eff_lc + CW'(1);
                        state_next = ST_UP_RD;
                    end
                    else if (eff_lc == '0 || sample >= ltop_reg)
                    begin
                        sel_next   = HEAP_UPPER;
                        val_next   = sample;
                        idx_next   = AW'(eff_uc);
                        uc_next    = eff_uc + CW'(1);
                        state_next = ST_UP_RD;
                    end
                    else
                    begin
                        sel_next   = HEAP_LOWER;
                        val_next   = sample;
                        idx_next   = '0;
                        n_next     = eff_lc;
                        moved_next = ltop_reg;
                        state_next = ST_DN_L;
                    end
                end
            end
            ST_UP_RD:
            begin
                if (idx_reg == '0)
                begin
                    wen        = 1'b1;
                    state_next = ST_FIN;
                end
                else
                begin
                    raddr      = parent[AW-1:0];
                    state_next = ST_UP_CMP;
                end
            end
            ST_UP_CMP:
            begin
                wen = 1'b1;
                if (ranks(sel_reg, val_reg, rdata))
                begin
                    wdata      = rdata;
                    idx_next   = parent[AW-1:0];
                    state_next = ST_UP_RD;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_DN_L:
            begin
                if (child_l >= IW'(n_reg))
                begin
                    wen        = 1'b1;
                    sel_next   = other;
                    val_next   = moved_reg;
                    idx_next   = AW'(other_cnt);
                    state_next = ST_UP_RD;
                    if (sel_reg == HEAP_UPPER)
                    begin
                        lc_next = lc_reg + CW'(1);
                    end
                    else
                    begin
                        uc_next = uc_reg + CW'(1);
                    end
                end
                else
                begin
                    raddr      = child_l[AW-1:0];
                    state_next = ST_DN_R;
                end
            end
            ST_DN_R:
            begin
                if (ranks(sel_reg, rdata, val_reg))
                begin
                    best_val_next = rdata;
                    best_idx_next = child_l[AW-1:0];
                    found_next    = 1'b1;
                end
                else
                begin
                    best_val_next = val_reg;
                    found_next    = 1'b0;
                end
                has_r_next = (child_r < IW'(n_reg));
                raddr      = child_r[AW-1:0];
                state_next = ST_DN_C;
            end
            ST_DN_C:
            begin
                wen = 1'b1;
                if (has_r_reg && ranks(sel_reg, rdata, best_val_reg))
                begin
                    wdata      = rdata;
                    idx_next   = child_r[AW-1:0];
                    state_next = ST_DN_L;
                end
                else if (found_reg)
                begin
                    wdata      = best_val_reg;
                    idx_next   = best_idx_reg;
                    state_next = ST_DN_L;
                end
                else
                begin
                    sel_next   = other;
                    val_next   = moved_reg;
                    idx_next   = AW'(other_cnt);
                    state_next = ST_UP_RD;
                    if (sel_reg == HEAP_UPPER)
                    begin
                        lc_next = lc_reg + CW'(1);
                    end
                    else
                    begin
                        uc_next = uc_reg + CW'(1);
                    end
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    held_next      = total[HELD_WIDTH-1:0];
                    if (uc_reg == '0)
                    begin
                        med_next = '0;
                    end
                    else if (total[0] || lc_reg == '0)
                    begin
                        med_next = {utop_reg, 1'b0};
                    end
                    else
                    begin
                        med_next = {utop_reg[SW-1], utop_reg} + {ltop_reg[SW-1], ltop_reg};
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            uc_reg        <= '0;
            lc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            uc_reg        <= uc_next;
            lc_reg        <= lc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg      <= sel_next;
        val_reg      <= val_next;
        idx_reg      <= idx_next;
        n_reg        <= n_next;
        best_val_reg <= best_val_next;
        best_idx_reg <= best_idx_next;
        found_reg    <= found_next;
        has_r_reg    <= has_r_next;
        moved_reg    <= moved_next;
        drop_reg     <= drop_next;
        med_reg      <= med_next;
        held_reg     <= held_next;
        if (state_reg == ST_FIN && (!out_valid_reg || !out_stall))
        begin
            odrop_reg <= drop_reg;
        end
        if (wen_up && waddr == '0)
        begin
            utop_reg <= wdata;
        end
        if (wen_lo && waddr == '0)
        begin
            ltop_reg <= wdata;
        end
    end

    assign in_stall       = (state_reg != ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign median_doubled = med_reg;
    assign samples_held   = held_reg;
    assign dropped        = odrop_reg;

    `include "running_median_two_heaps_core_assert.svh"

    `RMH_ASSERT_NOW(a_balanced, state_reg == ST_IDLE, uc_reg == lc_reg || uc_reg == lc_reg + CW'(1))
    `RMH_ASSERT_NOW(a_within_cap, state_reg == ST_IDLE, total <= TW'(CAPACITY))
    `RMH_ASSERT_NOW(a_one_store_write, 1'b1, !(wen_up && wen_lo))
    `RMH_ASSERT_NXT(a_leave_idle, in_valid && !in_stall, state_reg != ST_IDLE)

endmodule

// ===== hw/rtl/rmh_ram.sv =====
// Heap store: single-port-write, registered-read synchronous memory.
module rmh_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
